// ===== rtl/core/wma_pkg.sv =====
// Shared constants, types and state codes of the warm-up moving average.
package wma_pkg;

  // Number of samples averaged once the window has filled.
  localparam int WINDOW = 20;

  localparam int SAMPLE_W   = 12;
  localparam int FRAC_W     = 4;
  localparam int AVG_W      = 16;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W      = $clog2(WINDOW * 4095 + 1);
  localparam int DIVIDEND_W = SUM_W + FRAC_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  // Stream widths, padded to whole bytes.
  localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((AVG_W + 7) / 8) * 8;

  // Queue between the front and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // One division job handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               full;
  } wma_job_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

// ===== rtl/core/wma_front.sv =====
// Front end: takes samples, updates the sample ring, running sum and count.
module wma_front
  import wma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] sample,
  output wma_job_t            job
);

  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;
  logic [SUM_W-1:0]    sum;

  logic [SAMPLE_W-1:0] old_sample;
  logic [SLOT_W-1:0]   slot_next;
  logic [COUNT_W-1:0]  count_next;
  logic [SUM_W-1:0]    sum_next;
  logic                full;

  // Before the window fills, the slot being written has never held a sample,
  // so it reads as the cleared value.
  always_comb begin
    full       = (count == COUNT_W'(WINDOW));
    old_sample = full ? ring[slot] : '0;
    sum_next   = sum - SUM_W'(old_sample) + SUM_W'(sample);
    slot_next  = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
    count_next = full ? count : count + COUNT_W'(1);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (take) begin
      slot  <= slot_next;
      count <= count_next;
      sum   <= sum_next;
    end
  end

  // Sample ring.
  always_ff @(posedge clk) begin
    if (take) begin
      ring[slot] <= sample;
    end
  end

  // Job for the divider, formed in the cycle of the transfer.
  always_comb begin
    job.sum   = sum_next;
    job.count = count_next;
    job.full  = (count_next == COUNT_W'(WINDOW));
  end

endmodule

// ===== rtl/core/wma_queue.sv =====
// Short job queue that decouples the front end from the divider.
module wma_queue
  import wma_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  wma_job_t push_job,
  input  logic     pop,
  output wma_job_t pop_job,
  output logic     full,
  output logic     empty
);

  wma_job_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] fill;

  assign full    = (fill == QCOUNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCOUNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCOUNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/wma_divider.sv =====
// Back end: restoring divider, one quotient bit per cycle, and output register.
module wma_divider
  import wma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                job_ready,
  input  wma_job_t            job,
  output logic                job_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser
);

  div_state_t state;
  div_state_t state_next;

  logic [DIVIDEND_W-1:0] quo;
  logic [COUNT_W-1:0]    rem;
  logic [COUNT_W-1:0]    divisor;
  logic                  win_full;
  logic [STEP_W-1:0]     step;

  logic                  load_out;
  logic [COUNT_W:0]      rem_shift;
  logic [COUNT_W:0]      diff;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (job_ready) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step == '0) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    case (state)
      DIV_IDLE: job_pop  = job_ready;
      DIV_DONE: load_out = !m_tvalid || m_tready;
      default: begin
        job_pop  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    diff      = rem_shift - {1'b0, divisor};
  end

  // Division datapath. The dividend is the sum scaled by the fraction bits;
  // quotient bits shift in from the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      quo      <= {job.sum, FRAC_W'(0)};
      rem      <= '0;
      divisor  <= job.count;
      win_full <= job.full;
      step     <= STEP_W'(DIVIDEND_W - 1);
    end else if (state == DIV_RUN) begin
      step <= step - STEP_W'(1);
      if (!diff[COUNT_W]) begin
        rem <= diff[COUNT_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[COUNT_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= M_DATA_W'(quo[AVG_W-1:0]);
      m_tuser <= win_full;
    end
  end

endmodule

// ===== rtl/core/warmup_moving_average.sv =====
// Warm-up moving average: top level joining front end, job queue and divider.
//
// Boxcar mean of the last WINDOW (20) unsigned 12-bit samples, given as
// unsigned 12.4 fixed point, truncated. Until WINDOW samples have been taken
// the result is the mean of the samples seen so far, and tuser is low; from
// then on tuser is high. The front end takes a sample whenever the two-entry
// job queue has room. Each result then passes from the queue into the
// divider as a popped job, through a restoring divider that makes one
// quotient bit per cycle, and on to the output register. The divider sets
// the sustained rate, since it takes a new job only once it has handed the
// last result on; the rate is lower while the output register is held by
// backpressure. Short bursts of up to three samples are absorbed by the
// divider and the queue. No clearing pass is needed after reset.
module warmup_moving_average
  import wma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] sample, upper bits ignored
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [15:0] average
  output logic                m_tuser    // [0] window_full
);

  wma_job_t front_job;
  wma_job_t back_job;
  logic     take;
  logic     q_full;
  logic     q_empty;
  logic     job_pop;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  wma_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .sample (s_tdata[SAMPLE_W-1:0]),
    .job    (front_job)
  );

  wma_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_job (front_job),
    .pop      (job_pop),
    .pop_job  (back_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  wma_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!q_empty),
    .job       (back_job),
    .job_pop   (job_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
